[hw/rtl/tsr_pkg.sv]
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types, constants and helper functions of the twister rng block.
// ----------------------------------------------------------------------------
package tsr_pkg;

  // twister geometry
  localparam int unsigned IdxW    = 10;
  localparam logic [9:0]  Words   = 10'd624;
  localparam logic [9:0]  LastIdx = 10'd623;
  localparam logic [9:0]  Shift   = 10'd397;
  localparam logic [9:0]  FarWrap = 10'd227;

  // twister mixing constants
  localparam logic [31:0] TwUpper  = 32'h8000_0000;
  localparam logic [31:0] TwLower  = 32'h7FFF_FFFF;
  localparam logic [31:0] TwMatrix = 32'h9908_B0DF;

  // draw and linear generator constants
  localparam logic [31:0] Prime31    = 32'h7FFF_FFFF;
  localparam logic [31:0] TwoPrime31 = 32'hFFFF_FFFE;
  localparam logic [29:0] LcgMul     = 30'd907725;
  localparam logic [29:0] LcgAdd     = 30'd99979777;
  localparam logic [31:0] LcgSpan    = 32'h4000_0000;
  localparam logic [4:0]  SeedTwists = 5'd20;

  // command codes
  typedef enum logic [2:0] {
    FN_RANGE = 3'd0,
    FN_MOD   = 3'd1,
    FN_RAW   = 3'd2,
    FN_PUSH  = 3'd3,
    FN_POP   = 3'd4,
    FN_LCG   = 3'd5,
    FN_SEED  = 3'd6,
    FN_NONE  = 3'd7
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_BOUND = 2'd1,
    ST_OVERLOAD   = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WORD,
    S_WREAD,
    S_WCAP,
    S_DIVA,
    S_DIVB,
    S_FILL,
    S_TW_START,
    S_TW_LOAD,
    S_TW_RD,
    S_TW_WR,
    S_DONE
  } state_e;

  // divider request
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  // one twister recurrence step
  function automatic logic [31:0] twist_mix(input logic [31:0] hi, input logic [31:0] lo,
                                            input logic [31:0] far);
    logic [31:0] s;
    s = (hi & TwUpper) | (lo & TwLower);
    twist_mix = far ^ (s >> 1) ^ (s[0] ? TwMatrix : 32'd0);
  endfunction

  // one step of the 30-bit linear generator
  function automatic logic [31:0] lcg_next(input logic [31:0] x);
    logic [29:0] p;
    p = 30'(x[29:0] * LcgMul) + LcgAdd;
    lcg_next = {2'b00, p};
  endfunction

  // word modulo 2^31-1, the word is below three times the prime
  function automatic logic [31:0] prime_mod(input logic [31:0] w);
    if (w >= TwoPrime31) begin
      prime_mod = w - TwoPrime31;
    end else if (w >= Prime31) begin
      prime_mod = w - Prime31;
    end else begin
      prime_mod = w;
    end
  endfunction

endpackage

[hw/rtl/tsr_div.sv]
// ----------------------------------------------------------------------------
// tsr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsr_pkg::div_req_t  req_i,
  output logic               done_o,
  output logic [31:0]        quot_o,
  output logic [31:0]        rem_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] den_q;
  logic [32:0] trial;
  logic        fits;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem_q, quo_q[31]};
  assign fits  = trial >= {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= 32'd0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= 32'(trial - {1'b0, den_q});
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/tsr_mem.sv]
// ----------------------------------------------------------------------------
// tsr_mem
// Twister word store: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module tsr_mem #(
  parameter int unsigned Depth = 4992,
  parameter int unsigned AddrW = 13
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [31:0]      rdata_a_o,
  output logic [31:0]      rdata_b_o
);

  logic [31:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[hw/rtl/twister_rng_with_seed_stack.sv]
// ----------------------------------------------------------------------------
// twister_rng_with_seed_stack
// Stack of untempered MT19937 buffers with a shared 30-bit linear generator.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one result transaction. All buffer
// words live in one memory. A seed fill writes one word in each fill step, and a
// twist pass walks the buffer one word per read/write step pair. A modulo draw
// makes one pass through the divider, a ranged draw and a linear draw two. When
// the active buffer is used up, the draw first regenerates it with one twist
// pass. A push or a base seed fills its buffer and then runs 20 twist passes.
// Words of a buffer that was never seeded read as garbage; there is no clearing
// pass after reset. Results wait in an output register, and a new command is
// accepted while an earlier result still waits there.
module twister_rng_with_seed_stack #(
  parameter int unsigned BUFFERS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // func[2:0], bound[34:3], seed[66:35]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // value[31:0], status[33:32]
);

  localparam int unsigned BufW  = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
  localparam int unsigned Depth = BUFFERS * 624;
  localparam int unsigned AddrW = $clog2(Depth);

  // sequencer and command registers
  tsr_pkg::state_e  state_q, state_d;
  tsr_pkg::func_e   func_q, func_d;
  logic [31:0]      bound_q, bound_d;
  logic [31:0]      seed_q, seed_d;
  logic [31:0]      res_value_q, res_value_d;
  tsr_pkg::status_e res_status_q, res_status_d;

  // generator state
  logic [15:0]      depth_q, depth_d;
  logic [BufW-1:0]  active_q, active_d;
  logic [31:0]      lcg_q, lcg_d;
  logic [9:0]       pos_q [BUFFERS];
  logic [9:0]       pos_d [BUFFERS];

  // walk state
  logic [9:0]       idx_q, idx_d;
  logic [31:0]      cur_q, cur_d;
  logic [31:0]      word_q, word_d;
  logic [4:0]       twc_q, twc_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_value_q, out_value_d;
  tsr_pkg::status_e out_status_q, out_status_d;

  // memory and divider hookup
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [31:0]      mem_wdata, mem_rdata_a, mem_rdata_b;
  tsr_pkg::div_req_t div_req;
  logic             div_done;
  logic [31:0]      div_quot, div_rem;

  // derived values
  logic [AddrW-1:0] base;
  logic [9:0]       pos_cur;
  logic [9:0]       idx_next, idx_far;
  logic [15:0]      depth_inc, depth_dec;
  logic             word_func;

  function automatic logic [BufW-1:0] clamp_buf(input logic [15:0] d);
    clamp_buf = (d >= 16'(BUFFERS)) ? BufW'(BUFFERS - 1) : d[BufW-1:0];
  endfunction

  assign base      = AddrW'(active_q) * AddrW'(tsr_pkg::Words);
  assign pos_cur   = pos_q[active_q];
  assign idx_next  = (idx_q == tsr_pkg::LastIdx) ? 10'd0 : idx_q + 10'd1;
  assign idx_far   = (idx_q < tsr_pkg::FarWrap) ? idx_q + tsr_pkg::Shift
                                                : idx_q - tsr_pkg::FarWrap;
  assign depth_inc = (depth_q == 16'hFFFF) ? depth_q : depth_q + 16'd1;
  assign depth_dec = (depth_q == 16'd0) ? depth_q : depth_q - 16'd1;
  assign word_func = (func_q == tsr_pkg::FN_RAW) || (func_q == tsr_pkg::FN_MOD) ||
                     (func_q == tsr_pkg::FN_RANGE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsr_pkg::S_IDLE: begin
        if (s_axis_tvalid) state_d = tsr_pkg::S_DECODE;
      end
      tsr_pkg::S_DECODE: begin
        unique case (func_q)
          tsr_pkg::FN_RANGE: begin
            state_d = (bound_q < 32'd2) ? tsr_pkg::S_DONE : tsr_pkg::S_WORD;
          end
          tsr_pkg::FN_MOD: begin
            state_d = (bound_q == 32'd0) ? tsr_pkg::S_DONE : tsr_pkg::S_WORD;
          end
          tsr_pkg::FN_RAW: state_d = tsr_pkg::S_WORD;
          tsr_pkg::FN_PUSH, tsr_pkg::FN_SEED: state_d = tsr_pkg::S_FILL;
          tsr_pkg::FN_LCG: begin
            state_d = (bound_q == 32'd0) ? tsr_pkg::S_DONE : tsr_pkg::S_DIVA;
          end
          default: state_d = tsr_pkg::S_DONE;
        endcase
      end
      tsr_pkg::S_WORD: begin
        state_d = (pos_cur >= tsr_pkg::Words) ? tsr_pkg::S_TW_START : tsr_pkg::S_WREAD;
      end
      tsr_pkg::S_WREAD: state_d = tsr_pkg::S_WCAP;
      tsr_pkg::S_WCAP: begin
        if (func_q == tsr_pkg::FN_RAW) begin
          state_d = tsr_pkg::S_DONE;
        end else if (func_q == tsr_pkg::FN_MOD) begin
          state_d = tsr_pkg::S_DIVB;
        end else begin
          state_d = tsr_pkg::S_DIVA;
        end
      end
      tsr_pkg::S_DIVA: begin
        if (div_done) state_d = tsr_pkg::S_DIVB;
      end
      tsr_pkg::S_DIVB: begin
        if (div_done) state_d = tsr_pkg::S_DONE;
      end
      tsr_pkg::S_FILL: begin
        if (idx_q == tsr_pkg::LastIdx) state_d = tsr_pkg::S_TW_START;
      end
      tsr_pkg::S_TW_START: state_d = tsr_pkg::S_TW_LOAD;
      tsr_pkg::S_TW_LOAD:  state_d = tsr_pkg::S_TW_RD;
      tsr_pkg::S_TW_RD:    state_d = tsr_pkg::S_TW_WR;
      tsr_pkg::S_TW_WR: begin
        if (idx_q != tsr_pkg::LastIdx) begin
          state_d = tsr_pkg::S_TW_RD;
        end else if (twc_q != 5'd1) begin
          state_d = tsr_pkg::S_TW_START;
        end else begin
          state_d = word_func ? tsr_pkg::S_WORD : tsr_pkg::S_DONE;
        end
      end
      tsr_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = tsr_pkg::S_IDLE;
      end
      default: state_d = tsr_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    func_d       = func_q;
    bound_d      = bound_q;
    seed_d       = seed_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    depth_d      = depth_q;
    active_d     = active_q;
    lcg_d        = lcg_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    cur_d        = cur_q;
    word_d       = word_q;
    twc_d        = twc_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    mem_we       = 1'b0;
    mem_waddr    = base + AddrW'(idx_q);
    mem_wdata    = lcg_q;
    mem_raddr_a  = base + AddrW'(idx_next);
    mem_raddr_b  = base + AddrW'(idx_far);
    div_req      = '{start: 1'b0, dividend: word_q, divisor: bound_q};

    unique case (state_q)
      // capture the command
      tsr_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          func_d       = tsr_pkg::func_e'(s_axis_tdata[2:0]);
          bound_d      = s_axis_tdata[34:3];
          seed_d       = s_axis_tdata[66:35];
          res_value_d  = 32'd0;
          res_status_d = tsr_pkg::ST_OK;
        end
      end
      // stack moves, seeding setup and linear step
      tsr_pkg::S_DECODE: begin
        unique case (func_q)
          tsr_pkg::FN_RANGE, tsr_pkg::FN_MOD: begin
            if (bound_q == 32'd0) res_status_d = tsr_pkg::ST_ZERO_BOUND;
          end
          tsr_pkg::FN_PUSH: begin
            depth_d = depth_inc;
            active_d = clamp_buf(depth_inc);
            if (depth_inc >= 16'(BUFFERS)) res_status_d = tsr_pkg::ST_OVERLOAD;
            lcg_d = seed_q;
            idx_d = 10'd0;
            pos_d[clamp_buf(depth_inc)] = tsr_pkg::Words;
            twc_d = tsr_pkg::SeedTwists;
          end
          tsr_pkg::FN_POP: begin
            depth_d  = depth_dec;
            active_d = clamp_buf(depth_dec);
          end
          tsr_pkg::FN_LCG: begin
            if (bound_q == 32'd0) begin
              res_status_d = tsr_pkg::ST_ZERO_BOUND;
            end else begin
              lcg_d   = tsr_pkg::lcg_next(lcg_q);
              word_d  = tsr_pkg::lcg_next(lcg_q);
              div_req = '{start: 1'b1, dividend: tsr_pkg::LcgSpan, divisor: bound_q};
            end
          end
          tsr_pkg::FN_SEED: begin
            depth_d  = 16'd0;
            active_d = '0;
            lcg_d    = seed_q;
            idx_d    = 10'd0;
            pos_d[0] = tsr_pkg::Words;
            twc_d    = tsr_pkg::SeedTwists;
          end
          default: ;
        endcase
      end
      // exhausted buffer gets one regeneration pass
      tsr_pkg::S_WORD: begin
        if (pos_cur >= tsr_pkg::Words) begin
          pos_d[active_q] = 10'd0;
          twc_d = 5'd1;
        end
      end
      tsr_pkg::S_WREAD: begin
        mem_raddr_a = base + AddrW'(pos_cur);
        pos_d[active_q] = pos_cur + 10'd1;
      end
      tsr_pkg::S_WCAP: begin
        if (func_q == tsr_pkg::FN_RAW) begin
          res_value_d = mem_rdata_a;
        end else if (func_q == tsr_pkg::FN_MOD) begin
          div_req = '{start: 1'b1, dividend: mem_rdata_a, divisor: bound_q};
        end else begin
          word_d  = tsr_pkg::prime_mod(mem_rdata_a);
          div_req = '{start: 1'b1, dividend: tsr_pkg::Prime31, divisor: bound_q};
        end
      end
      // scale divisor ready, divide the draw by it
      tsr_pkg::S_DIVA: begin
        if (div_done) begin
          div_req = '{start: 1'b1, dividend: word_q, divisor: div_quot + 32'd1};
        end
      end
      tsr_pkg::S_DIVB: begin
        if (div_done) begin
          res_value_d = (func_q == tsr_pkg::FN_MOD) ? div_rem : div_quot;
        end
      end
      // fill the buffer from the linear generator
      tsr_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = base + AddrW'(idx_q);
        mem_wdata = lcg_q;
        lcg_d     = tsr_pkg::lcg_next(lcg_q);
        idx_d     = idx_next;
      end
      // twist pass: prime word 0, then read next and far, write back
      tsr_pkg::S_TW_START: begin
        mem_raddr_a = base;
      end
      tsr_pkg::S_TW_LOAD: begin
        cur_d = mem_rdata_a;
        idx_d = 10'd0;
      end
      tsr_pkg::S_TW_RD: begin
        mem_raddr_a = base + AddrW'(idx_next);
        mem_raddr_b = base + AddrW'(idx_far);
      end
      tsr_pkg::S_TW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = base + AddrW'(idx_q);
        mem_wdata = tsr_pkg::twist_mix(cur_q, mem_rdata_a, mem_rdata_b);
        cur_d     = mem_rdata_a;
        idx_d     = idx_next;
        if (idx_q == tsr_pkg::LastIdx && twc_q != 5'd1) twc_d = twc_q - 5'd1;
      end
      // hand the result to the output register
      tsr_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsr_pkg::S_IDLE;
      depth_q     <= 16'd0;
      active_q    <= '0;
      lcg_q       <= 32'd0;
      out_valid_q <= 1'b0;
      twc_q       <= 5'd0;
      for (int i = 0; i < BUFFERS; i++) pos_q[i] <= tsr_pkg::Words;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      active_q    <= active_d;
      lcg_q       <= lcg_d;
      out_valid_q <= out_valid_d;
      twc_q       <= twc_d;
      pos_q       <= pos_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    bound_q      <= bound_d;
    seed_q       <= seed_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    idx_q        <= idx_d;
    cur_q        <= cur_d;
    word_q       <= word_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  tsr_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  tsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  // ports
  assign s_axis_tready = (state_q == tsr_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_status_q, out_value_q};

  // no memory write outside a fill or a twist write-back
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == tsr_pkg::S_FILL || state_q == tsr_pkg::S_TW_WR))
    else $error("memory written outside fill or twist");

  // active buffer stays on the stack
  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= BufW'(BUFFERS - 1))
    else $error("active buffer out of range");

  // divider finishes only while a division is awaited
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == tsr_pkg::S_DIVA || state_q == tsr_pkg::S_DIVB))
    else $error("divider result with nobody waiting");

  // a twist pass never starts with no twist left to do
  a_twist_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsr_pkg::S_TW_START) |-> (twc_q != 5'd0))
    else $error("twist started with zero count");

endmodule
